FILE: hw/rtl/dps_pkg.sv
// dps_pkg: shared types and codes of the dynamic priority scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

	// item kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_SCHED = 1'b1;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_ADDED    = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_RAN      = 3'd2;
	localparam status_t ST_FINISHED = 3'd3;
	localparam status_t ST_IDLE     = 3'd4;

	// field widths
	localparam int ID_W    = 8;
	localparam int TIME_W  = 8;
	localparam int PRIO_W  = 8;
	localparam int ENTRY_W = ID_W + TIME_W + PRIO_W;

	localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted item, restart the scan
		logic step;    // read one slot and advance the scan counter
		logic finish;  // update the table and emit the result beat
	} dps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // scan counter at the last slot
	} dps_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dps_ram.sv
// dps_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dps_ctrl.sv
// dps_ctrl: sequencing state machine of the scheduler
// depends on dps_pkg
`timescale 1ns / 1ps
`default_nettype none

module dps_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output dps_pkg::dps_cmd_t       cmd,
	input  wire dps_pkg::dps_stat_t stat
);
	import dps_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last read comes back and is compared
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("busy held after result beat");

endmodule

`default_nettype wire

FILE: hw/rtl/dps_datapath.sv
// dps_datapath: slot table, scan and compare logic, result registers
// depends on dps_pkg and dps_ram
`timescale 1ns / 1ps
`default_nettype none

module dps_datapath #(
	parameter int MAX_PROCESSES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dps_pkg::dps_cmd_t            cmd,
	output dps_pkg::dps_stat_t                stat,
	input  wire logic                         kind,
	input  wire logic [7:0]                   process_id,
	input  wire logic [7:0]                   time_slice,
	input  wire logic signed [7:0]            start_priority,
	output logic                              done,
	output dps_pkg::status_t                  status,
	output logic [7:0]                        run_id,
	output logic [7:0]                        time_left,
	output logic signed [7:0]                 new_priority
);
	import dps_pkg::*;

	localparam int SLOT_W = $clog2(MAX_PROCESSES);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCESSES - 1);

	// captured item
	logic                     kind_q;
	logic [ID_W-1:0]          id_q;
	logic [TIME_W-1:0]        time_q;
	logic signed [PRIO_W-1:0] prio_q;

	// scan state
	logic [SLOT_W-1:0]        cnt_q;
	logic                     scan_s1;
	logic [SLOT_W-1:0]        slot_s1;
	logic                     vld_s1;
	logic                     found_q;
	logic [SLOT_W-1:0]        best_slot_q;
	logic [ID_W-1:0]          best_id_q;
	logic [TIME_W-1:0]        best_time_q;
	logic signed [PRIO_W-1:0] best_prio_q;

	logic [MAX_PROCESSES-1:0] valid_q;

	// ram
	logic                     ram_we;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic [ID_W-1:0]          rd_id;
	logic [TIME_W-1:0]        rd_time;
	logic signed [PRIO_W-1:0] rd_prio;

	// update values
	logic [TIME_W-1:0]        dec_time;
	logic signed [PRIO_W-1:0] dec_prio;
	logic                     add_ok;
	logic                     sched_ok;

	dps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PROCESSES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (best_slot_q),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_id   = ram_rdata[ENTRY_W-1 -: ID_W];
	assign rd_time = ram_rdata[PRIO_W +: TIME_W];
	assign rd_prio = $signed(ram_rdata[PRIO_W-1:0]);

	assign stat.scan_last = (cnt_q == LAST_SLOT);

	assign add_ok   = cmd.finish && (kind_q == KIND_ADD) && found_q;
	assign sched_ok = cmd.finish && (kind_q == KIND_SCHED) && found_q;

	assign dec_time = (best_time_q != '0) ? best_time_q - TIME_W'(1) : '0;
	assign dec_prio = (best_prio_q == PRIO_MIN) ? PRIO_MIN : best_prio_q - PRIO_W'(1);

	assign ram_we    = add_ok || sched_ok;
	assign ram_wdata = add_ok ? {id_q, time_q, prio_q} : {best_id_q, dec_time, dec_prio};

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			id_q   <= process_id;
			time_q <= time_slice;
			prio_q <= start_priority;
		end
	end

	// scan counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.step;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= cnt_q;
		vld_s1  <= valid_q[cnt_q];
	end

	// running best: first free slot for an add, highest priority for a schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (scan_s1) begin
			if (kind_q == KIND_ADD) begin
				if (!vld_s1) begin
					found_q <= 1'b1;
				end
			end else if (vld_s1) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1) begin
			if (kind_q == KIND_ADD) begin
				if (!vld_s1 && !found_q) begin
					best_slot_q <= slot_s1;
				end
			end else if (vld_s1 && (!found_q || rd_prio > best_prio_q)) begin
				// strict compare keeps the lowest slot on a tie
				best_slot_q <= slot_s1;
				best_id_q   <= rd_id;
				best_time_q <= rd_time;
				best_prio_q <= rd_prio;
			end
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (add_ok) begin
			valid_q[best_slot_q] <= 1'b1;
		end else if (sched_ok && dec_time == '0) begin
			valid_q[best_slot_q] <= 1'b0;
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (kind_q == KIND_ADD) begin
				status       <= found_q ? ST_ADDED : ST_FULL;
				run_id       <= id_q;
				time_left    <= '0;
				new_priority <= '0;
			end else if (found_q) begin
				status       <= (dec_time == '0) ? ST_FINISHED : ST_RAN;
				run_id       <= best_id_q;
				time_left    <= dec_time;
				new_priority <= dec_prio;
			end else begin
				status       <= ST_IDLE;
				run_id       <= '0;
				time_left    <= '0;
				new_priority <= '0;
			end
		end
	end

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.finish))
		else $error("result beat without finish command");

	a_add_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |=> valid_q[$past(best_slot_q)])
		else $error("added slot not marked valid");

	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FINISHED |-> time_left == '0)
		else $error("finished process reported with time left");

endmodule

`default_nettype wire

FILE: hw/rtl/dynamic_priority_scheduler.sv
// dynamic_priority_scheduler: highest priority first scheduler with priority decay
// an accepted item runs a table scan of one slot per cycle through the single read port of the
// entry ram, the drain state, the update state and the result register; busy stays high until
// the result beat, so items do not overlap; add and schedule items take the same time
// reset: arst_n clears the controller, scan control and all slot valid bits (table empty) at once
// results are strobed for one cycle on done; the receiver cannot stall them
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_scheduler #(
	parameter int MAX_PROCESSES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command side: an item is taken when start is high and busy is low
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [7:0]        process_id,
	input  wire logic [7:0]        time_slice,
	input  wire logic signed [7:0] start_priority,
	// result side: one beat per item, valid for the single cycle that done is high
	output logic                   done,
	output dps_pkg::status_t       status,
	output logic [7:0]             run_id,
	output logic [7:0]             time_left,
	output logic signed [7:0]      new_priority
);
	import dps_pkg::*;

	// command and status between the sequencer and the datapath
	dps_cmd_t  cmd;
	dps_stat_t stat;

	// sequencer: idle, scan every slot, drain the last ram read, update and report
	dps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	// datapath: entry ram, valid bits, running best slot and the result register
	// an add looks for the lowest free slot, a schedule for the highest priority,
	// lowest slot winning a tie; priority decays by one and saturates at its minimum
	dps_datapath #(
		.MAX_PROCESSES(MAX_PROCESSES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.process_id     (process_id),
		.time_slice     (time_slice),
		.start_priority (start_priority),
		.done           (done),
		.status         (status),
		.run_id         (run_id),
		.time_left      (time_left),
		.new_priority   (new_priority)
	);

endmodule

`default_nettype wire
